@@ hw/rtl/modular_exponentiation_macros.svh @@
// Assertion macros for the modular exponentiation block.
// Used by modular_exponentiation.sv; expects clk and arst_n in scope.
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define MEX_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define MEX_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/modexp_pkg.sv @@
// Types and fixed constants for the modular exponentiation block.
// No dependencies; imported by modular_exponentiation.sv.
package modexp_pkg;

	// Fixed field widths of the ports
	localparam int DATA_W = 32;
	localparam int EXP_W  = 31;

	// Sequencer states, one-hot
	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_REDUCE = 6'b000010,
		S_SEQ    = 6'b000100,
		S_DBL    = 6'b001000,
		S_ADD    = 6'b010000,
		S_DONE   = 6'b100000
	} mex_state_t;

endpackage

@@ hw/rtl/modular_exponentiation.sv @@
// Sequence: base reduction by restoring division, then per modular multiply one setup
//   step and a shift-and-add over the multiplier bits, one multiply per set exponent bit
//   and one square per exponent bit below the top one; a final state loads the output.
// Flow: one word at a time; in_ready is high only between items, while the sequencer
//   is idle; all arithmetic goes through the single shared add/compare/subtract unit.
// Reset: arst_n clears the sequencer and the output valid; data registers are not reset.
`include "modular_exponentiation_macros.svh"

module modular_exponentiation
	import modexp_pkg::*;
#(
	parameter int WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [DATA_W-1:0] base,
	input  logic [EXP_W-1:0]  exponent,
	input  logic [DATA_W-1:0] modulus,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] power_result
);

	localparam int CNT_W = $clog2(WIDTH);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

	mex_state_t state_q;

	logic [WIDTH-1:0] m_q;      // modulus
	logic [WIDTH-1:0] b_q;      // running base
	logic [WIDTH-1:0] acc_q;    // accumulator
	logic [WIDTH-1:0] x_q;      // multiplicand
	logic [WIDTH-1:0] y_q;      // multiplier / dividend, shifted MSB first
	logic [WIDTH-1:0] r_q;      // partial remainder / partial product
	logic [EXP_W-1:0] e_q;      // remaining exponent bits
	logic [CNT_W-1:0] cnt_q;
	logic             sq_phase_q;  // multiply of this exponent bit already done
	logic             tgt_sq_q;    // current multiply is a square
	logic             out_valid_q;
	logic [DATA_W-1:0] power_result_q;

	// Size conversion between port width and datapath width
	logic [WIDTH+DATA_W-1:0] base_ext;
	logic [WIDTH+DATA_W-1:0] mod_ext;
	logic [WIDTH+DATA_W-1:0] acc_ext;
	logic [WIDTH-1:0]        base_w;
	logic [WIDTH-1:0]        mod_w;
	logic [DATA_W-1:0]       acc_out;

	assign base_ext = {{WIDTH{1'b0}}, base};
	assign mod_ext  = {{WIDTH{1'b0}}, modulus};
	assign acc_ext  = {{DATA_W{1'b0}}, acc_q};
	assign base_w   = base_ext[WIDTH-1:0];
	assign mod_w    = mod_ext[WIDTH-1:0];
	assign acc_out  = acc_ext[DATA_W-1:0];

	// Shared unit: (r + opb + cin) mod m, for operands below m
	logic [WIDTH-1:0] opb;
	logic             cin;
	logic [WIDTH:0]   sum;
	logic [WIDTH:0]   diff;
	logic             ge;
	logic [WIDTH-1:0] res;

	assign opb  = (state_q == S_ADD) ? x_q : r_q;
	assign cin  = (state_q == S_REDUCE) & y_q[WIDTH-1];
	assign sum  = {1'b0, r_q} + {1'b0, opb} + {{WIDTH{1'b0}}, cin};
	assign diff = sum - {1'b0, m_q};
	assign ge   = sum >= {1'b0, m_q};
	assign res  = ge ? diff[WIDTH-1:0] : sum[WIDTH-1:0];

	logic accept_in;
	logic out_free;
	logic last_bit;

	assign accept_in = in_valid & in_ready;
	assign out_free  = ~out_valid_q | out_ready;
	assign last_bit  = (cnt_q == '0);

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept_in) begin
						state_q <= (mod_w[WIDTH-1:1] == '0) ? S_DONE : S_REDUCE;
					end
				end
				S_REDUCE: begin
					if (last_bit) begin
						state_q <= S_SEQ;
					end
				end
				S_SEQ: begin
					if (e_q == '0) begin
						state_q <= S_DONE;
					end else if (!sq_phase_q && e_q[0]) begin
						state_q <= S_DBL;
					end else if (e_q[EXP_W-1:1] == '0) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_DBL;
					end
				end
				S_DBL: begin
					if (y_q[WIDTH-1]) begin
						state_q <= S_ADD;
					end else if (last_bit) begin
						state_q <= S_SEQ;
					end
				end
				S_ADD: begin
					state_q <= last_bit ? S_SEQ : S_DBL;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept_in) begin
					m_q        <= mod_w;
					e_q        <= exponent;
					y_q        <= base_w;
					r_q        <= '0;
					cnt_q      <= CNT_LAST;
					sq_phase_q <= 1'b0;
					// modulus one or zero yields zero
					acc_q      <= (mod_w[WIDTH-1:1] == '0) ? '0 : WIDTH'(1);
				end
			end
			S_REDUCE: begin
				// restoring division step: shift in the next base bit
				r_q   <= res;
				y_q   <= y_q << 1;
				cnt_q <= cnt_q - 1'b1;
				if (last_bit) begin
					b_q <= res;
				end
			end
			S_SEQ: begin
				r_q   <= '0;
				cnt_q <= CNT_LAST;
				if (!sq_phase_q && e_q[0]) begin
					x_q      <= acc_q;
					y_q      <= b_q;
					tgt_sq_q <= 1'b0;
				end else begin
					x_q      <= b_q;
					y_q      <= b_q;
					tgt_sq_q <= 1'b1;
				end
			end
			S_DBL, S_ADD: begin
				r_q <= res;
				// advance to the next multiplier bit unless an add is pending
				if (state_q == S_ADD || !y_q[WIDTH-1]) begin
					y_q   <= y_q << 1;
					cnt_q <= cnt_q - 1'b1;
					if (last_bit) begin
						if (tgt_sq_q) begin
							b_q        <= res;
							e_q        <= e_q >> 1;
							sq_phase_q <= 1'b0;
						end else begin
							acc_q      <= res;
							sq_phase_q <= 1'b1;
						end
					end
				end
			end
			S_DONE: begin
				if (out_free) begin
					power_result_q <= acc_out;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign power_result = power_result_q;

	// Checks
	`MEX_ASSERT_NXT(a_busy_after_accept, accept_in, !in_ready, "accepted word did not start work")
	`MEX_ASSERT_IMP(a_partial_reduced,
		(state_q == S_REDUCE) || (state_q == S_DBL) || (state_q == S_ADD),
		r_q < m_q, "partial remainder not below modulus")
	`MEX_ASSERT_IMP(a_operands_reduced, state_q == S_SEQ,
		(acc_q < m_q) && (b_q < m_q), "accumulator or base not below modulus")
	`MEX_ASSERT_NXT(a_hold_result, (state_q == S_DONE) && out_valid_q && !out_ready,
		(state_q == S_DONE) && out_valid_q, "pending result overwritten")

endmodule
